// ===== rtl/prs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prs_pkg
// Shared constants, codes and types for the page replacement core.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int SLOTS_DEF     = 16;
  localparam int PAGES_DEF     = 16;
  localparam int PROCESSES_DEF = 128;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [0:0] REG_POLICY = 1'b0;

  localparam logic POL_FIFO = 1'b0;
  localparam logic POL_LRU  = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT   = 3'd0,
    ST_FILL  = 3'd1,
    ST_EVICT = 3'd2,
    ST_SWAP  = 3'd3,
    ST_BAD   = 3'd4,
    ST_HALT  = 3'd5
  } status_t;

  // frame table update: load a new page, or refresh recency on a hit
  typedef struct packed {
    logic load;
    logic touch;
  } frame_op_t;

endpackage
`default_nettype wire

// ===== rtl/page_replacement_with_swap_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// page_replacement_with_swap_core
// FIFO/LRU page replacement over primary frames with swap to secondary slots.
// ----------------------------------------------------------------------------
// Sequence: an accepted request walks the frame table (S_FSCAN), then the slot
//   table (S_SSCAN), updates the tables (S_UPDATE) and registers its result in
//   S_DONE once the output is free; bad page or halted requests go straight to
//   S_DONE. A new request is taken only after the result is pushed. One comparator
//   walks the frame table then the slot table, one entry per cycle.
// Reset: synchronous; clears frame and slot valid bits, ranks, halt flag and
//   sets policy to FIFO. No clearing pass.
module page_replacement_with_swap_core import prs_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int SLOTS     = SLOTS_DEF,
  parameter int PAGES     = PAGES_DEF,
  parameter int PROCESSES = PROCESSES_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [ADDR_W-1:0]             paddr,
  input  wire [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready,
  input  wire                          req_valid,
  output logic                         req_ready,
  input  wire [$clog2(PROCESSES)-1:0]  pid,
  input  wire [$clog2(PAGES+1)-1:0]    page,
  output logic                         res_valid,
  input  wire                          res_ready,
  output logic [2:0]                   status,
  output logic [$clog2(FRAMES)-1:0]    frame,
  output logic [$clog2(SLOTS)-1:0]     slot,
  output logic [$clog2(PROCESSES)-1:0] victim_pid,
  output logic [$clog2(PAGES+1)-1:0]   victim_page,
  output logic                         secondary_full
);

  localparam int FW   = $clog2(FRAMES);
  localparam int SW   = $clog2(SLOTS);
  localparam int PW   = $clog2(PROCESSES);
  localparam int GW   = $clog2(PAGES+1);
  localparam int MAXN = (FRAMES > SLOTS) ? FRAMES : SLOTS;
  localparam int CW   = $clog2(MAXN+1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FSCAN  = 5'b00010,
    S_SSCAN  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          cmp_en;
  logic [CW-1:0] cmp_idx;
  logic          policy;
  logic          halted;

  logic [PW-1:0] req_pid;
  logic [GW-1:0] req_page;

  logic          hit_found, free_found, best_found, sec_found, frees_found;
  logic [FW-1:0] hit_idx, free_idx, best_idx, best_rank;
  logic [SW-1:0] sec_idx, frees_idx;
  logic [PW-1:0] vpid;
  logic [GW-1:0] vpage;

  status_t       rslt_status;
  logic [FW-1:0] rslt_frame;
  logic [SW-1:0] rslt_slot;
  logic [PW-1:0] rslt_vpid;
  logic [GW-1:0] rslt_vpage;
  logic          rslt_full;

  // table interfaces
  logic [PW-1:0]     f_rd_pid, s_rd_pid;
  logic [GW-1:0]     f_rd_page, s_rd_page;
  logic [FRAMES-1:0] f_valid;
  logic [SLOTS-1:0]  s_valid;
  logic [FW-1:0]     f_rank;
  frame_op_t         f_op;
  logic [FW-1:0]     f_op_addr;
  logic              s_wr;
  logic [SW-1:0]     s_wr_addr;

  // shared comparator
  logic [PW-1:0] cmp_pid;
  logic [GW-1:0] cmp_page;
  logic          ent_valid;
  logic          key_match;

  logic          accept;
  logic          cfg_wr;
  logic          bad_page;
  logic          is_swap, is_fill;
  logic [FW-1:0] tgt;
  status_t       upd_status;
  logic          halt_after;
  logic          push;

  assign pready    = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2:2] == REG_POLICY);
  assign prdata    = (paddr[2:2] == REG_POLICY) ? DATA_W'(policy) : '0;
  assign bad_page  = (page == '0) || (page > GW'(PAGES));
  assign push      = (state == S_DONE) && (!res_valid || res_ready);

  always_comb begin
    if (state == S_SSCAN) begin
      cmp_pid   = s_rd_pid;
      cmp_page  = s_rd_page;
      ent_valid = s_valid[cmp_idx[SW-1:0]];
    end else begin
      cmp_pid   = f_rd_pid;
      cmp_page  = f_rd_page;
      ent_valid = f_valid[cmp_idx[FW-1:0]];
    end
    key_match = (cmp_pid == req_pid) && (cmp_page == req_page);
  end

  always_comb begin
    is_swap = !hit_found && sec_found;
    is_fill = !hit_found && !sec_found && free_found;
    if (hit_found)       tgt = hit_idx;
    else if (is_fill)    tgt = free_idx;
    else if (best_found) tgt = best_idx;
    else                 tgt = '0;
    if (hit_found)    upd_status = ST_HIT;
    else if (is_swap) upd_status = ST_SWAP;
    else if (is_fill) upd_status = ST_FILL;
    else              upd_status = ST_EVICT;
    f_op.load  = (state == S_UPDATE) && !hit_found;
    f_op.touch = (state == S_UPDATE) && hit_found;
    f_op_addr  = (state == S_UPDATE) ? tgt : cmp_idx[FW-1:0];
    s_wr       = (state == S_UPDATE) && !hit_found && !is_fill;
    if (is_swap)          s_wr_addr = sec_idx;
    else if (frees_found) s_wr_addr = frees_idx;
    else                  s_wr_addr = '0;
    halt_after = halted || s_valid[SLOTS-1] || (s_wr && s_wr_addr == SW'(SLOTS-1));
  end

  prs_frame_store #(
    .FRAMES    (FRAMES),
    .PAGES     (PAGES),
    .PROCESSES (PROCESSES)
  ) u_frames (
    .clk      (clk),
    .rst      (rst),
    .policy   (policy),
    .rd_addr  (cnt[FW-1:0]),
    .rd_pid   (f_rd_pid),
    .rd_page  (f_rd_page),
    .op       (f_op),
    .op_addr  (f_op_addr),
    .wr_pid   (req_pid),
    .wr_page  (req_page),
    .valid    (f_valid),
    .rank_out (f_rank)
  );

  prs_slot_store #(
    .SLOTS     (SLOTS),
    .PAGES     (PAGES),
    .PROCESSES (PROCESSES)
  ) u_slots (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (cnt[SW-1:0]),
    .rd_pid  (s_rd_pid),
    .rd_page (s_rd_page),
    .wr_en   (s_wr),
    .wr_addr (s_wr_addr),
    .wr_pid  (vpid),
    .wr_page (vpage),
    .valid   (s_valid)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      cmp_en      <= 1'b0;
      policy      <= POL_FIFO;
      halted      <= 1'b0;
      res_valid   <= 1'b0;
      hit_found   <= 1'b0;
      free_found  <= 1'b0;
      best_found  <= 1'b0;
      sec_found   <= 1'b0;
      frees_found <= 1'b0;
    end else begin
      if (cfg_wr) policy <= pwdata[0];
      if (push)                        res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt         <= '0;
            cmp_en      <= 1'b0;
            hit_found   <= 1'b0;
            free_found  <= 1'b0;
            best_found  <= 1'b0;
            sec_found   <= 1'b0;
            frees_found <= 1'b0;
            state       <= (halted || bad_page) ? S_DONE : S_FSCAN;
          end
        end
        S_FSCAN: begin
          if (cmp_en) begin
            if (ent_valid && key_match) hit_found <= 1'b1;
            if (!ent_valid) free_found <= 1'b1;
            if (ent_valid && (!best_found || f_rank > best_rank)) best_found <= 1'b1;
          end
          if (cnt == CW'(FRAMES)) begin
            cnt    <= '0;
            cmp_en <= 1'b0;
            state  <= S_SSCAN;
          end else begin
            cnt    <= cnt + CW'(1);
            cmp_en <= 1'b1;
          end
        end
        S_SSCAN: begin
          if (cmp_en) begin
            if (ent_valid && key_match) sec_found <= 1'b1;
            if (!ent_valid) frees_found <= 1'b1;
          end
          if (cnt == CW'(SLOTS)) begin
            cnt    <= '0;
            cmp_en <= 1'b0;
            state  <= S_UPDATE;
          end else begin
            cnt    <= cnt + CW'(1);
            cmp_en <= 1'b1;
          end
        end
        S_UPDATE: begin
          halted <= halt_after;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (push) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cmp_idx <= cnt;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          req_pid     <= pid;
          req_page    <= page;
          vpid        <= '0;
          vpage       <= '0;
          rslt_status <= halted ? ST_HALT : ST_BAD;
          rslt_frame  <= '0;
          rslt_slot   <= '0;
          rslt_vpid   <= '0;
          rslt_vpage  <= '0;
          rslt_full   <= halted;
        end
      end
      S_FSCAN: begin
        if (cmp_en) begin
          if (ent_valid && key_match && !hit_found) hit_idx <= cmp_idx[FW-1:0];
          if (!ent_valid && !free_found) free_idx <= cmp_idx[FW-1:0];
          if (ent_valid && (!best_found || f_rank > best_rank)) begin
            best_idx  <= cmp_idx[FW-1:0];
            best_rank <= f_rank;
            vpid      <= f_rd_pid;
            vpage     <= f_rd_page;
          end
        end
      end
      S_SSCAN: begin
        if (cmp_en) begin
          if (ent_valid && key_match && !sec_found) sec_idx <= cmp_idx[SW-1:0];
          if (!ent_valid && !frees_found) frees_idx <= cmp_idx[SW-1:0];
        end
      end
      S_UPDATE: begin
        rslt_status <= upd_status;
        rslt_frame  <= tgt;
        rslt_slot   <= s_wr ? s_wr_addr : '0;
        rslt_vpid   <= s_wr ? vpid : '0;
        rslt_vpage  <= s_wr ? vpage : '0;
        rslt_full   <= halt_after;
      end
      S_DONE: begin
        if (push) begin
          status         <= rslt_status;
          frame          <= rslt_frame;
          slot           <= rslt_slot;
          victim_pid     <= rslt_vpid;
          victim_page    <= rslt_vpage;
          secondary_full <= rslt_full;
        end
      end
      default: ;
    endcase
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt flag cleared");

  a_halt_tracks_last: assert property (@(posedge clk) disable iff (rst)
    halted == s_valid[SLOTS-1])
    else $error("halt flag out of step with last slot");

  a_halt_reports_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == ST_HALT) |-> secondary_full)
    else $error("halted result without full flag");

  a_hit_no_slot_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && hit_found) |-> !s_wr && f_op.touch && !f_op.load)
    else $error("hit changed secondary storage");

  a_fscan_to_sscan: assert property (@(posedge clk) disable iff (rst)
    (state == S_FSCAN && cnt == CW'(FRAMES)) |=> (state == S_SSCAN && cnt == '0))
    else $error("frame scan did not hand over to slot scan");

endmodule
`default_nettype wire

// ===== rtl/prs_frame_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prs_frame_store
// Primary frame table: pid/page storage, valid bits and exact age ranks.
// ----------------------------------------------------------------------------
module prs_frame_store import prs_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGES     = PAGES_DEF,
  parameter int PROCESSES = PROCESSES_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   policy,
  input  wire [$clog2(FRAMES)-1:0]              rd_addr,
  output logic [$clog2(PROCESSES)-1:0]          rd_pid,
  output logic [$clog2(PAGES+1)-1:0]            rd_page,
  input  wire frame_op_t                        op,
  input  wire [$clog2(FRAMES)-1:0]              op_addr,
  input  wire [$clog2(PROCESSES)-1:0]           wr_pid,
  input  wire [$clog2(PAGES+1)-1:0]             wr_page,
  output logic [FRAMES-1:0]                     valid,
  output logic [$clog2(FRAMES)-1:0]             rank_out
);

  localparam int FW = $clog2(FRAMES);
  localparam int PW = $clog2(PROCESSES);
  localparam int GW = $clog2(PAGES+1);

  logic [PW-1:0] pid_mem  [FRAMES];
  logic [GW-1:0] page_mem [FRAMES];
  logic [FW-1:0] ins_rank [FRAMES];
  logic [FW-1:0] rec_rank [FRAMES];

  logic [FW-1:0] cur_ins;
  logic [FW-1:0] cur_rec;
  logic          cur_valid;

  always_ff @(posedge clk) begin
    if (op.load) begin
      pid_mem[op_addr]  <= wr_pid;
      page_mem[op_addr] <= wr_page;
    end
    rd_pid  <= pid_mem[rd_addr];
    rd_page <= page_mem[rd_addr];
  end

  always_comb begin
    cur_ins   = ins_rank[op_addr];
    cur_rec   = rec_rank[op_addr];
    cur_valid = valid[op_addr];
    rank_out  = (policy == POL_LRU) ? cur_rec : cur_ins;
  end

  // loaded frame becomes newest and frames newer than its old rank age by one; a touch renews recency only
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        ins_rank[i] <= '0;
        rec_rank[i] <= '0;
      end
    end else begin
      for (int i = 0; i < FRAMES; i++) begin
        if (op.load) begin
          if (FW'(i) == op_addr) begin
            ins_rank[i] <= '0;
            rec_rank[i] <= '0;
            valid[i]    <= 1'b1;
          end else if (valid[i]) begin
            if (!cur_valid || ins_rank[i] < cur_ins) ins_rank[i] <= ins_rank[i] + FW'(1);
            if (!cur_valid || rec_rank[i] < cur_rec) rec_rank[i] <= rec_rank[i] + FW'(1);
          end
        end else if (op.touch) begin
          if (FW'(i) == op_addr) begin
            rec_rank[i] <= '0;
          end else if (valid[i] && rec_rank[i] < cur_rec) begin
            rec_rank[i] <= rec_rank[i] + FW'(1);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/prs_slot_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// prs_slot_store
// Secondary slot table: pid/page memory with registered read, valid bits.
// ----------------------------------------------------------------------------
module prs_slot_store import prs_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int PAGES     = PAGES_DEF,
  parameter int PROCESSES = PROCESSES_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire [$clog2(SLOTS)-1:0]      rd_addr,
  output logic [$clog2(PROCESSES)-1:0] rd_pid,
  output logic [$clog2(PAGES+1)-1:0]   rd_page,
  input  wire                          wr_en,
  input  wire [$clog2(SLOTS)-1:0]      wr_addr,
  input  wire [$clog2(PROCESSES)-1:0]  wr_pid,
  input  wire [$clog2(PAGES+1)-1:0]    wr_page,
  output logic [SLOTS-1:0]             valid
);

  localparam int PW = $clog2(PROCESSES);
  localparam int GW = $clog2(PAGES+1);

  logic [PW-1:0] pid_mem  [SLOTS];
  logic [GW-1:0] page_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pid_mem[wr_addr]  <= wr_pid;
      page_mem[wr_addr] <= wr_page;
    end
    rd_pid  <= pid_mem[rd_addr];
    rd_page <= page_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the page replacement core against a cycle-free model of its frame
// and slot tables. Requests come from a small pool of process/page pairs, so
// fills, hits, evictions and swaps repeat under both FIFO and LRU policy
// without filling secondary storage. Near the end, fresh pairs drive the core
// into the halted state. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top import prs_pkg::*; ;

  localparam int PID_W  = $clog2(PROCESSES_DEF);
  localparam int PAGE_W = $clog2(PAGES_DEF + 1);
  localparam int FRM_W  = $clog2(FRAMES_DEF);
  localparam int SLT_W  = $clog2(SLOTS_DEF);
  localparam int POOL_N = 22;
  localparam logic [ADDR_W-1:0] POLICY_ADDR = ADDR_W'(REG_POLICY) << 2;

  typedef struct {
    status_t            status;
    logic [FRM_W-1:0]   frame;
    logic [SLT_W-1:0]   slot;
    logic [PID_W-1:0]   vpid;
    logic [PAGE_W-1:0]  vpage;
    logic               full;
  } outcome_t;

  class swap_tracker;
    bit                fvalid [FRAMES_DEF];
    logic [PID_W-1:0]  fpid   [FRAMES_DEF];
    logic [PAGE_W-1:0] fpage  [FRAMES_DEF];
    bit [FRM_W-1:0]    rank   [2][FRAMES_DEF]; // 0 insertion age, 1 recency age
    bit                svalid [SLOTS_DEF];
    logic [PID_W-1:0]  spid   [SLOTS_DEF];
    logic [PAGE_W-1:0] spage  [SLOTS_DEF];
    bit                halted;
    bit                policy;
    int                errors;
    outcome_t          pending [$];

    function void renew(int order, int f, int lim);
      for (int i = 0; i < FRAMES_DEF; i++)
        if (i != f && fvalid[i] && int'(rank[order][i]) < lim) rank[order][i]++;
      rank[order][f] = '0;
    endfunction

    function int oldest();
      int best, best_rank;
      best = 0;
      best_rank = -1;
      for (int i = 0; i < FRAMES_DEF; i++) begin
        if (fvalid[i] && int'(rank[policy][i]) > best_rank) begin
          best_rank = rank[policy][i];
          best = i;
        end
      end
      return best;
    endfunction

    function void load(int f, logic [PID_W-1:0] p, logic [PAGE_W-1:0] pg);
      int li, lr;
      li = fvalid[f] ? int'(rank[0][f]) : FRAMES_DEF;
      lr = fvalid[f] ? int'(rank[1][f]) : FRAMES_DEF;
      renew(0, f, li);
      renew(1, f, lr);
      fvalid[f] = 1'b1;
      fpid[f]   = p;
      fpage[f]  = pg;
    endfunction

    function void note_access(logic [PID_W-1:0] p, logic [PAGE_W-1:0] pg);
      outcome_t o;
      int hit, sec, freef, frees, f, s;
      hit = -1; sec = -1; freef = -1; frees = -1;
      o.status = ST_HIT; o.frame = '0; o.slot = '0; o.vpid = '0; o.vpage = '0;
      if (halted) begin
        o.status = ST_HALT;
      end else if (pg < 1 || pg > PAGES_DEF) begin
        o.status = ST_BAD;
      end else begin
        for (int i = 0; i < FRAMES_DEF; i++) begin
          if (fvalid[i] && fpid[i] == p && fpage[i] == pg && hit < 0) hit = i;
          if (!fvalid[i] && freef < 0) freef = i;
        end
        for (int i = 0; i < SLOTS_DEF; i++) begin
          if (svalid[i] && spid[i] == p && spage[i] == pg && sec < 0) sec = i;
          if (!svalid[i] && frees < 0) frees = i;
        end
        if (hit >= 0) begin
          o.frame = hit[FRM_W-1:0];
          renew(1, hit, rank[1][hit]);
        end else if (sec >= 0 || freef < 0) begin
          o.status = (sec >= 0) ? ST_SWAP : ST_EVICT;
          f = oldest();
          s = (sec >= 0) ? sec : ((frees >= 0) ? frees : 0);
          o.slot  = s[SLT_W-1:0];
          o.vpid  = fpid[f];
          o.vpage = fpage[f];
          spid[s]   = fpid[f];
          spage[s]  = fpage[f];
          svalid[s] = 1'b1;
          load(f, p, pg);
          o.frame = f[FRM_W-1:0];
        end else begin
          o.status = ST_FILL;
          o.frame  = freef[FRM_W-1:0];
          load(freef, p, pg);
        end
        if (svalid[SLOTS_DEF-1]) halted = 1'b1;
      end
      o.full = (o.status == ST_HALT) || svalid[SLOTS_DEF-1];
      pending.push_back(o);
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, actual status %0d", $time, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare("status", want.status, got.status);
      compare("frame", want.frame, got.frame);
      compare("slot", want.slot, got.slot);
      compare("victim_pid", want.vpid, got.vpid);
      compare("victim_page", want.vpage, got.vpage);
      compare("secondary_full", want.full, got.full);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic [PID_W-1:0]    req_pid = '0;
  logic [PAGE_W-1:0]   req_page = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  logic [2:0]          status;
  logic [FRM_W-1:0]    frame;
  logic [SLT_W-1:0]    slot;
  logic [PID_W-1:0]    victim_pid;
  logic [PAGE_W-1:0]   victim_page;
  logic                secondary_full;

  bit                  no_idle = 1'b0;
  swap_tracker         tracker = new;
  logic [PID_W-1:0]    pool_pid  [POOL_N + 8];
  logic [PAGE_W-1:0]   pool_page [POOL_N + 8];

  page_replacement_with_swap_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready), .pid(req_pid), .page(req_page),
    .res_valid(res_valid), .res_ready(res_ready), .status(status), .frame(frame),
    .slot(slot), .victim_pid(victim_pid), .victim_page(victim_page),
    .secondary_full(secondary_full)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    outcome_t got;
    if (!rst && res_valid && res_ready) begin
      got.status = status_t'(status);
      got.frame  = frame;
      got.slot   = slot;
      got.vpid   = victim_pid;
      got.vpage  = victim_page;
      got.full   = secondary_full;
      tracker.check_outcome(got);
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 9) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      res_ready <= 1'b1;
    end
  end

  function automatic bit known_pair(logic [PID_W-1:0] p, logic [PAGE_W-1:0] pg, int n);
    for (int i = 0; i < n; i++)
      if (pool_pid[i] == p && pool_page[i] == pg) return 1'b1;
    return 1'b0;
  endfunction

  task automatic send_access(input logic [PID_W-1:0] p, input logic [PAGE_W-1:0] pg);
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_pid   <= p;
    req_page  <= pg;
    do @(posedge clk); while (!req_ready);
    tracker.note_access(p, pg);
  endtask

  task automatic touch(input int k);
    send_access(pool_pid[k], pool_page[k]);
  endtask

  task automatic random_access();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      send_access(PID_W'($urandom_range(0, 127)),
                  $urandom_range(0, 1) ? PAGE_W'(0) : PAGE_W'($urandom_range(17, 31)));
    else if (r < 50)
      touch($urandom_range(0, 9));
    else
      touch($urandom_range(0, POOL_N - 1));
  endtask

  // stop requesting until every outstanding result is back
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_policy(input bit val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= POLICY_ADDR; pwdata <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.policy = val;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic read_policy();
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= POLICY_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(tracker.policy)) begin
      $display("%0t: policy readback mismatch: expected %0d, actual %0d",
               $time, tracker.policy, prdata);
      tracker.errors++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  initial begin
    int n_known;
    logic [PID_W-1:0]  p;
    logic [PAGE_W-1:0] pg;

    pool_pid[0] = '0;  pool_page[0] = PAGE_W'(1);
    pool_pid[1] = '1;  pool_page[1] = PAGE_W'(PAGES_DEF);
    for (int k = 2; k < POOL_N; k++) begin
      do begin
        pool_pid[k]  = PID_W'($urandom_range(0, 127));
        pool_page[k] = PAGE_W'($urandom_range(1, PAGES_DEF));
      end while (known_pair(pool_pid[k], pool_page[k], k));
    end
    n_known = POOL_N;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // bad pages, fills, hits, FIFO evictions and a swap back
    send_access(PID_W'(127), PAGE_W'(0));
    send_access(PID_W'(0), PAGE_W'(31));
    send_access(PID_W'(85), PAGE_W'(17));
    for (int k = 0; k < FRAMES_DEF; k++) touch(k);
    touch(1);
    touch(0);
    touch(8);
    touch(9);
    touch(0);
    drain();

    write_policy(POL_LRU);
    read_policy();
    touch(3);
    touch(10);
    touch(11);
    touch(1);
    touch(2);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_policy((ph % 2 == 0) ? POL_FIFO : POL_LRU);
      read_policy();
      for (int n = 0; n < 120; n++) begin
        random_access();
        if (n == 60) drain();
      end
      drain();
    end

    no_idle = 1'b1;
    repeat (20) random_access();
    // new pairs fill the remaining slots until the core halts
    while (!tracker.halted) begin
      do begin
        p  = PID_W'($urandom_range(0, 127));
        pg = PAGE_W'($urandom_range(1, PAGES_DEF));
      end while (known_pair(p, pg, n_known));
      pool_pid[n_known]  = p;
      pool_page[n_known] = pg;
      n_known++;
      send_access(p, pg);
    end
    repeat (10) send_access(PID_W'($urandom_range(0, 127)), PAGE_W'($urandom_range(0, 31)));
    drain();
    repeat (40) @(posedge clk);

    if (tracker.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/prs_pkg.sv
rtl/prs_frame_store.sv
rtl/prs_slot_store.sv
rtl/page_replacement_with_swap_core.sv
tb/tb_top.sv
